/* design/rtch_pkg.sv */
package rtch_pkg;

  typedef enum logic [2:0] {
    CFG_ORIGIN_X      = 3'd0,
    CFG_ORIGIN_Y      = 3'd1,
    CFG_ORIGIN_Z      = 3'd2,
    CFG_DIR_X         = 3'd3,
    CFG_DIR_Y         = 3'd4,
    CFG_DIR_Z         = 3'd5,
    CFG_MAX_DISTANCE  = 3'd6,
    CFG_DET_THRESHOLD = 3'd7
  } cfg_idx_e;

  // multiplicand sources
  typedef enum logic [3:0] {
    A_E1_0, A_E1_1, A_E1_2,
    A_P0,   A_P1,   A_P2,
    A_S0,   A_S1,   A_S2,
    A_Q0,   A_Q1,   A_Q2
  } a_sel_e;

  // multiplier sources, consumed one byte per cycle
  typedef enum logic [3:0] {
    B_D0,   B_D1,   B_D2,
    B_E0_0, B_E0_1, B_E0_2,
    B_S0,   B_S1,   B_S2,
    B_E1_0, B_E1_1, B_E1_2
  } b_sel_e;

  typedef enum logic [3:0] {
    DST_NONE, DST_P0, DST_P1, DST_P2, DST_DET, DST_UN,
    DST_Q0, DST_Q1, DST_Q2, DST_VN, DST_TN
  } dst_e;

  typedef struct packed {
    a_sel_e a_sel;
    b_sel_e b_sel;
    logic   sub;
    dst_e   dst;
  } uop_t;

  typedef struct packed {
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
    logic [31:0]        max_distance;
    logic [15:0]        det_threshold;
  } back_cfg_t;

  localparam int NUM_UOPS  = 24;
  localparam int UOP_IDX_W = 5;

  // P = D x E1, det = E0.P, un = S.P, Q = S x E0, vn = D.Q, tn = E1.Q
  function automatic uop_t uop_at(logic [UOP_IDX_W-1:0] idx);
    uop_t u;
    unique case (idx)
      5'd0:  u = '{A_E1_2, B_D1,   1'b0, DST_NONE};
      5'd1:  u = '{A_E1_1, B_D2,   1'b1, DST_P0};
      5'd2:  u = '{A_E1_0, B_D2,   1'b0, DST_NONE};
      5'd3:  u = '{A_E1_2, B_D0,   1'b1, DST_P1};
      5'd4:  u = '{A_E1_1, B_D0,   1'b0, DST_NONE};
      5'd5:  u = '{A_E1_0, B_D1,   1'b1, DST_P2};
      5'd6:  u = '{A_P0,   B_E0_0, 1'b0, DST_NONE};
      5'd7:  u = '{A_P1,   B_E0_1, 1'b0, DST_NONE};
      5'd8:  u = '{A_P2,   B_E0_2, 1'b0, DST_DET};
      5'd9:  u = '{A_P0,   B_S0,   1'b0, DST_NONE};
      5'd10: u = '{A_P1,   B_S1,   1'b0, DST_NONE};
      5'd11: u = '{A_P2,   B_S2,   1'b0, DST_UN};
      5'd12: u = '{A_S1,   B_E0_2, 1'b0, DST_NONE};
      5'd13: u = '{A_S2,   B_E0_1, 1'b1, DST_Q0};
      5'd14: u = '{A_S2,   B_E0_0, 1'b0, DST_NONE};
      5'd15: u = '{A_S0,   B_E0_2, 1'b1, DST_Q1};
      5'd16: u = '{A_S0,   B_E0_1, 1'b0, DST_NONE};
      5'd17: u = '{A_S1,   B_E0_0, 1'b1, DST_Q2};
      5'd18: u = '{A_Q0,   B_D0,   1'b0, DST_NONE};
      5'd19: u = '{A_Q1,   B_D1,   1'b0, DST_NONE};
      5'd20: u = '{A_Q2,   B_D2,   1'b0, DST_VN};
      5'd21: u = '{A_Q0,   B_E1_0, 1'b0, DST_NONE};
      5'd22: u = '{A_Q1,   B_E1_1, 1'b0, DST_NONE};
      5'd23: u = '{A_Q2,   B_E1_2, 1'b0, DST_TN};
      default: u = '{A_E1_0, B_D0, 1'b0, DST_NONE};
    endcase
    return u;
  endfunction

endpackage

/* design/rtch_front.sv */
module rtch_front #(
  parameter int COORD_BITS = 24,
  parameter int ID_BITS    = 16,
  parameter int ENT_W      = 9 * (COORD_BITS + 1) + ID_BITS + 1
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic signed [COORD_BITS-1:0] origin_x_i,
  input  logic signed [COORD_BITS-1:0] origin_y_i,
  input  logic signed [COORD_BITS-1:0] origin_z_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [9*COORD_BITS-1:0]      in_vert_i,
  input  logic [ID_BITS-1:0]           in_id_i,
  input  logic                         in_fin_i,
  output logic                         ent_valid_o,
  input  logic                         ent_ready_i,
  output logic [ENT_W-1:0]             ent_o
);
  import rtch_pkg::*;

  localparam int EW = COORD_BITS + 1;

  logic signed [EW-1:0] ax, ay, az, bx, by, bz, cx, cy, cz;
  logic [ENT_W-1:0]     ent_new;
  logic [ENT_W-1:0]     fifo_q [2];
  logic                 wr_ptr_q, rd_ptr_q;
  logic [1:0]           cnt_q;
  logic                 push, pop;

  assign ax = EW'($signed(in_vert_i[0*COORD_BITS +: COORD_BITS]));
  assign ay = EW'($signed(in_vert_i[1*COORD_BITS +: COORD_BITS]));
  assign az = EW'($signed(in_vert_i[2*COORD_BITS +: COORD_BITS]));
  assign bx = EW'($signed(in_vert_i[3*COORD_BITS +: COORD_BITS]));
  assign by = EW'($signed(in_vert_i[4*COORD_BITS +: COORD_BITS]));
  assign bz = EW'($signed(in_vert_i[5*COORD_BITS +: COORD_BITS]));
  assign cx = EW'($signed(in_vert_i[6*COORD_BITS +: COORD_BITS]));
  assign cy = EW'($signed(in_vert_i[7*COORD_BITS +: COORD_BITS]));
  assign cz = EW'($signed(in_vert_i[8*COORD_BITS +: COORD_BITS]));

  // entry: E0, E1, S (x lowest), id, final flag
  assign ent_new = {in_fin_i, in_id_i,
                    EW'($signed(origin_z_i)) - az, EW'($signed(origin_y_i)) - ay,
                    EW'($signed(origin_x_i)) - ax,
                    cz - az, cy - ay, cx - ax,
                    bz - az, by - ay, bx - ax};

  assign in_ready_o  = (cnt_q != 2'd2);
  assign push        = in_valid_i && in_ready_o;
  assign ent_valid_o = (cnt_q != 2'd0);
  assign pop         = ent_valid_o && ent_ready_i;
  assign ent_o       = fifo_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) begin
        fifo_q[wr_ptr_q] <= ent_new;
        wr_ptr_q         <= ~wr_ptr_q;
      end
      if (pop) rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

endmodule

/* design/rtch_back.sv */
module rtch_back #(
  parameter int COORD_BITS = 24,
  parameter int ID_BITS    = 16,
  parameter int ENT_W      = 9 * (COORD_BITS + 1) + ID_BITS + 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  rtch_pkg::back_cfg_t  cfg_i,
  input  logic                 restart_i,
  input  logic [31:0]          restart_dist_i,
  input  logic                 ent_valid_i,
  output logic                 ent_ready_o,
  input  logic [ENT_W-1:0]     ent_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 out_hit_o,
  output logic [31:0]          out_hit_dist_o,
  output logic                 out_done_o,
  output logic                 out_found_o,
  output logic [ID_BITS-1:0]   out_best_id_o,
  output logic [31:0]          out_best_dist_o
);
  import rtch_pkg::*;

  localparam int EW  = COORD_BITS + 1;
  localparam int BW  = (EW > 16) ? EW : 16;
  localparam int NB  = (BW + 7) / 8;
  localparam int MW  = NB * 8;
  localparam int AW  = 3 * EW + 30;
  localparam int DCW = (NB > 2) ? $clog2(NB) : 1;

  typedef enum logic [2:0] {
    ST_IDLE, ST_LOAD, ST_MUL, ST_ACC, ST_CHECK, ST_DIV, ST_UPD
  } state_e;

  state_e               state_q;
  logic signed [AW-1:0] e0_q [3];
  logic signed [AW-1:0] e1_q [3];
  logic signed [AW-1:0] s_q  [3];
  logic signed [AW-1:0] p_q  [3];
  logic signed [AW-1:0] qv_q [3];
  logic signed [AW-1:0] det_q, un_q, vn_q, tn_q;
  logic signed [AW-1:0] acc_q, prod_q, mcand_q;
  logic                 acc_clr_q;
  logic [MW-1:0]        mplr_q;
  logic [DCW-1:0]       dig_q;
  logic [UOP_IDX_W-1:0] uidx_q;
  logic [ID_BITS-1:0]   id_q;
  logic                 fin_q, hit_q;
  logic [31:0]          dist_q;
  logic [AW-1:0]        rem_q;
  logic [31:0]          numlo_q;
  logic [4:0]           div_cnt_q;
  logic [31:0]          closest_q;
  logic [ID_BITS-1:0]   best_id_q;
  logic                 found_q;
  logic                 out_valid_q;

  uop_t                 uop;
  logic signed [AW-1:0] a_val;
  logic signed [MW-1:0] b_val;
  logic signed [8:0]    dig9;
  logic signed [AW+8:0] mterm;
  logic signed [AW-1:0] prod_nx, acc_base, acc_sum;
  logic [AW-1:0]        thr_ext;
  logic                 hit_c, sat_c;
  logic [AW:0]          r2, r2_sub;
  logic                 ge;
  logic                 better;

  assign uop = uop_at(uidx_q);

  always_comb begin
    case (uop.a_sel)
      A_E1_0:  a_val = e1_q[0];
      A_E1_1:  a_val = e1_q[1];
      A_E1_2:  a_val = e1_q[2];
      A_P0:    a_val = p_q[0];
      A_P1:    a_val = p_q[1];
      A_P2:    a_val = p_q[2];
      A_S0:    a_val = s_q[0];
      A_S1:    a_val = s_q[1];
      A_S2:    a_val = s_q[2];
      A_Q0:    a_val = qv_q[0];
      A_Q1:    a_val = qv_q[1];
      A_Q2:    a_val = qv_q[2];
      default: a_val = '0;
    endcase
    case (uop.b_sel)
      B_D0:    b_val = MW'(cfg_i.dir_x);
      B_D1:    b_val = MW'(cfg_i.dir_y);
      B_D2:    b_val = MW'(cfg_i.dir_z);
      B_E0_0:  b_val = e0_q[0][MW-1:0];
      B_E0_1:  b_val = e0_q[1][MW-1:0];
      B_E0_2:  b_val = e0_q[2][MW-1:0];
      B_S0:    b_val = s_q[0][MW-1:0];
      B_S1:    b_val = s_q[1][MW-1:0];
      B_S2:    b_val = s_q[2][MW-1:0];
      B_E1_0:  b_val = e1_q[0][MW-1:0];
      B_E1_1:  b_val = e1_q[1][MW-1:0];
      B_E1_2:  b_val = e1_q[2][MW-1:0];
      default: b_val = '0;
    endcase
  end

  // most significant byte first; only that one carries the sign
  assign dig9    = (dig_q == '0) ? {mplr_q[MW-1], mplr_q[MW-1 -: 8]}
                                 : {1'b0, mplr_q[MW-1 -: 8]};
  assign mterm   = mcand_q * dig9;
  assign prod_nx = (prod_q <<< 8) + $signed(mterm[AW-1:0]);

  assign acc_base = acc_clr_q ? '0 : acc_q;
  assign acc_sum  = uop.sub ? (acc_base - prod_q) : (acc_base + prod_q);

  assign thr_ext = (cfg_i.det_threshold == 16'd0) ? AW'(1) : AW'(cfg_i.det_threshold);
  assign hit_c   = (det_q >= $signed(thr_ext)) && !un_q[AW-1] && (un_q <= det_q) &&
                   !vn_q[AW-1] && ((un_q + vn_q) <= det_q) && !tn_q[AW-1];
  assign sat_c   = (det_q <<< 10) <= tn_q;

  assign r2     = {rem_q, numlo_q[31]};
  assign r2_sub = r2 - {1'b0, det_q};
  assign ge     = r2 >= {1'b0, det_q};

  assign better = hit_q && (dist_q <= closest_q);

  assign ent_ready_o = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      closest_q   <= 32'hFFFF_FFFF;
      best_id_q   <= '0;
      found_q     <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      if (restart_i) begin
        closest_q <= restart_dist_i;
        best_id_q <= '0;
        found_q   <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (ent_valid_i) begin
            for (int i = 0; i < 3; i++) begin
              e0_q[i] <= AW'($signed(ent_i[i*EW +: EW]));
              e1_q[i] <= AW'($signed(ent_i[(3+i)*EW +: EW]));
              s_q[i]  <= AW'($signed(ent_i[(6+i)*EW +: EW]));
            end
            id_q      <= ent_i[9*EW +: ID_BITS];
            fin_q     <= ent_i[ENT_W-1];
            uidx_q    <= '0;
            acc_clr_q <= 1'b1;
            state_q   <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          mcand_q <= a_val;
          mplr_q  <= b_val;
          prod_q  <= '0;
          dig_q   <= '0;
          state_q <= ST_MUL;
        end
        ST_MUL: begin
          prod_q <= prod_nx;
          mplr_q <= mplr_q << 8;
          dig_q  <= dig_q + 1'b1;
          if (dig_q == DCW'(NB - 1)) state_q <= ST_ACC;
        end
        ST_ACC: begin
          acc_q     <= acc_sum;
          acc_clr_q <= (uop.dst != DST_NONE);
          case (uop.dst)
            DST_P0:  p_q[0]  <= acc_sum;
            DST_P1:  p_q[1]  <= acc_sum;
            DST_P2:  p_q[2]  <= acc_sum;
            DST_DET: det_q   <= acc_sum;
            DST_UN:  un_q    <= acc_sum;
            DST_Q0:  qv_q[0] <= acc_sum;
            DST_Q1:  qv_q[1] <= acc_sum;
            DST_Q2:  qv_q[2] <= acc_sum;
            DST_VN:  vn_q    <= acc_sum;
            DST_TN:  tn_q    <= acc_sum;
            default: ;
          endcase
          if (uidx_q == UOP_IDX_W'(NUM_UOPS - 1)) begin
            state_q <= ST_CHECK;
          end else begin
            uidx_q  <= uidx_q + 1'b1;
            state_q <= ST_LOAD;
          end
        end
        ST_CHECK: begin
          hit_q     <= hit_c;
          rem_q     <= AW'(tn_q >>> 10);
          numlo_q   <= {tn_q[9:0], 22'd0};
          div_cnt_q <= '0;
          if (!hit_c) begin
            dist_q  <= '0;
            state_q <= ST_UPD;
          end else if (sat_c) begin
            dist_q  <= 32'hFFFF_FFFF;
            state_q <= ST_UPD;
          end else begin
            dist_q  <= '0;
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          rem_q     <= ge ? r2_sub[AW-1:0] : r2[AW-1:0];
          numlo_q   <= numlo_q << 1;
          dist_q    <= {dist_q[30:0], ge};
          div_cnt_q <= div_cnt_q + 1'b1;
          if (div_cnt_q == 5'd31) state_q <= ST_UPD;
        end
        ST_UPD: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q     <= 1'b1;
            out_hit_o       <= hit_q;
            out_hit_dist_o  <= dist_q;
            out_done_o      <= fin_q;
            out_found_o     <= found_q || better;
            out_best_id_o   <= better ? id_q : best_id_q;
            out_best_dist_o <= better ? dist_q : closest_q;
            if (fin_q) begin
              closest_q <= cfg_i.max_distance;
              best_id_q <= '0;
              found_q   <= 1'b0;
            end else if (better) begin
              closest_q <= dist_q;
              best_id_q <= id_q;
              found_q   <= 1'b1;
            end
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

/* design/ray_triangle_closest_hit_unit.sv */
// Moller-Trumbore ray/triangle test with back-face culling and a closest-hit
// search. Each slave transaction is one triangle (A, B, C, id; tlast marks the
// last candidate of a query) and yields one master transaction with this
// triangle's hit and distance (Q10.22, saturated) and the best hit so far; the
// search restarts after the tlast item and on a write of max_distance. All
// products are exact; one shared byte-serial multiplier forms them, taking
// N = ceil(max(COORD_BITS+1,16)/8) multiplier bytes in turn for each of the
// 24 micro-ops; a check and, when the distance needs it, the bit-serial
// divider follow. A two-entry queue in front keeps accepting triangles
// while one is being worked on, until it is full.
module ray_triangle_closest_hit_unit #(
  parameter int COORD_BITS = 24,
  parameter int ID_BITS    = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [2:0]             cfg_idx_i,
  input  logic [31:0]            cfg_data_i,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, tri_id
  input  logic [((9*COORD_BITS+ID_BITS+7)/8)*8-1:0] s_axis_tdata,
  input  logic                   s_axis_tlast,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // hit, hit_distance, found, best_id, best_distance
  output logic [((66+ID_BITS+7)/8)*8-1:0] m_axis_tdata,
  output logic                   m_axis_tlast
);
  import rtch_pkg::*;

  localparam int ENT_W  = 9 * (COORD_BITS + 1) + ID_BITS + 1;
  localparam int OUT_W  = 66 + ID_BITS;
  localparam int OUT_TW = ((OUT_W + 7) / 8) * 8;

  logic signed [COORD_BITS-1:0] origin_x_q, origin_y_q, origin_z_q;
  back_cfg_t                    cfg_q;
  logic                         restart;
  logic                         ent_valid, ent_ready;
  logic [ENT_W-1:0]             ent;
  logic                         o_hit, o_found;
  logic [31:0]                  o_hit_dist, o_best_dist;
  logic [ID_BITS-1:0]           o_best_id;

  assign restart = cfg_we_i && (cfg_idx_e'(cfg_idx_i) == CFG_MAX_DISTANCE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q          <= '0;
      origin_y_q          <= '0;
      origin_z_q          <= '0;
      cfg_q.dir_x         <= 16'sd16384;
      cfg_q.dir_y         <= '0;
      cfg_q.dir_z         <= '0;
      cfg_q.max_distance  <= 32'hFFFF_FFFF;
      cfg_q.det_threshold <= 16'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_ORIGIN_X:      origin_x_q          <= cfg_data_i[COORD_BITS-1:0];
        CFG_ORIGIN_Y:      origin_y_q          <= cfg_data_i[COORD_BITS-1:0];
        CFG_ORIGIN_Z:      origin_z_q          <= cfg_data_i[COORD_BITS-1:0];
        CFG_DIR_X:         cfg_q.dir_x         <= cfg_data_i[15:0];
        CFG_DIR_Y:         cfg_q.dir_y         <= cfg_data_i[15:0];
        CFG_DIR_Z:         cfg_q.dir_z         <= cfg_data_i[15:0];
        CFG_MAX_DISTANCE:  cfg_q.max_distance  <= cfg_data_i;
        CFG_DET_THRESHOLD: cfg_q.det_threshold <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  rtch_front #(
    .COORD_BITS(COORD_BITS),
    .ID_BITS   (ID_BITS),
    .ENT_W     (ENT_W)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .origin_x_i (origin_x_q),
    .origin_y_i (origin_y_q),
    .origin_z_i (origin_z_q),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_vert_i  (s_axis_tdata[9*COORD_BITS-1:0]),
    .in_id_i    (s_axis_tdata[9*COORD_BITS +: ID_BITS]),
    .in_fin_i   (s_axis_tlast),
    .ent_valid_o(ent_valid),
    .ent_ready_i(ent_ready),
    .ent_o      (ent)
  );

  rtch_back #(
    .COORD_BITS(COORD_BITS),
    .ID_BITS   (ID_BITS),
    .ENT_W     (ENT_W)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .restart_i      (restart),
    .restart_dist_i (cfg_data_i),
    .ent_valid_i    (ent_valid),
    .ent_ready_o    (ent_ready),
    .ent_i          (ent),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .out_hit_o      (o_hit),
    .out_hit_dist_o (o_hit_dist),
    .out_done_o     (m_axis_tlast),
    .out_found_o    (o_found),
    .out_best_id_o  (o_best_id),
    .out_best_dist_o(o_best_dist)
  );

  assign m_axis_tdata = OUT_TW'({o_best_dist, o_best_id, o_found, o_hit_dist, o_hit});

endmodule
